FILE: sv/pdec_pkg.sv
// ----------------------------------------------------------------------------
// pdec_pkg: shared types and constants of the percent decoder
// Word formats, configuration register indexes, escape state codes and the
// small character helpers that the decoder uses.
// ----------------------------------------------------------------------------
package pdec_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} raw_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       out_last;
	} dec_word_t;

	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_PLUS_TO_SPACE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEEP_RESERVED = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MASK_LOW      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MASK_HIGH     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DROP_CONTROLS = 3'd4;

	typedef struct packed {
		logic        plus_to_space;
		logic        keep_reserved;
		logic [63:0] mask_low;
		logic [63:0] mask_high;
		logic        drop_controls;
	} cfg_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_PLUS  = 8'h2B;

	typedef enum logic [1:0] {
		PEND_IDLE  = 2'd0,
		PEND_PCT   = 2'd1,
		PEND_DIGIT = 2'd2
	} pend_t;

	// Up to three result words produced by one raw word.
	localparam int GRP_N = 3;

	typedef struct packed {
		logic [GRP_N-1:0][7:0] bytes;
		logic [1:0]            count;
		logic                  has_byte;
		logic                  last;
	} grp_t;

	function automatic logic is_hex(input logic [7:0] b);
		return (b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] b);
		logic [7:0] v;
		if (b inside {[8'h30:8'h39]}) begin
			v = b - 8'h30;
		end else if (b inside {[8'h61:8'h66]}) begin
			v = b - 8'h57;
		end else begin
			v = b - 8'h37;
		end
		return v[3:0];
	endfunction

endpackage

FILE: sv/pdec_cfg.sv
// ----------------------------------------------------------------------------
// pdec_cfg: configuration registers
// Holds the mode bits and the reserved-character mask written over the
// plain write port. Indexes beyond the register list are ignored.
// ----------------------------------------------------------------------------
module pdec_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pdec_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pdec_pkg::CFG_DATA_W-1:0]   cfg_data,
	output pdec_pkg::cfg_t                    cfg
);
	import pdec_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.plus_to_space <= 1'b0;
			cfg_q.keep_reserved <= 1'b0;
			cfg_q.mask_low      <= '0;
			cfg_q.mask_high     <= '0;
			cfg_q.drop_controls <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PLUS_TO_SPACE: cfg_q.plus_to_space <= cfg_data[0];
				CFG_KEEP_RESERVED: cfg_q.keep_reserved <= cfg_data[0];
				CFG_MASK_LOW:      cfg_q.mask_low      <= cfg_data;
				CFG_MASK_HIGH:     cfg_q.mask_high     <= cfg_data;
				CFG_DROP_CONTROLS: cfg_q.drop_controls <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: sv/pdec_decode.sv
// ----------------------------------------------------------------------------
// pdec_decode: escape state and single-pass decode
// Turns one registered raw word into a group of up to three result words
// and advances the escape state when the group is handed on.
// ----------------------------------------------------------------------------
module pdec_decode (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pdec_pkg::cfg_t       cfg,
	input  pdec_pkg::raw_word_t  word_s1,
	input  logic                 step,
	output pdec_pkg::grp_t       grp
);
	import pdec_pkg::*;

	pend_t      pend_q, pend_nx;
	logic [7:0] fd_q, fd_nx;

	logic [GRP_N-1:0][7:0] slot;
	logic [2:0]            cnt;
	logic                  has;
	logic                  idle;
	logic [7:0]            b;
	logic [7:0]            code;
	logic                  reserved;
	logic                  control;

	assign b    = word_s1.in_byte;
	assign code = {hex_val(fd_q), hex_val(b)};
	assign reserved = cfg.keep_reserved && !code[7] &&
		(code[6] ? cfg.mask_high[code[5:0]] : cfg.mask_low[code[5:0]]);
	assign control = cfg.drop_controls &&
		(code == CH_NUL || code == CH_LF || code == CH_CR);

	always_comb begin
		slot    = '0;
		cnt     = 3'd0;
		has     = 1'b1;
		idle    = 1'b0;
		pend_nx = pend_q;
		fd_nx   = fd_q;

		case (pend_q)
			PEND_PCT: begin
				if (is_hex(b)) begin
					fd_nx   = b;
					pend_nx = PEND_DIGIT;
				end else begin
					slot[cnt[1:0]] = CH_PCT;
					cnt = cnt + 3'd1;
					idle = 1'b1;
				end
			end
			PEND_DIGIT: begin
				pend_nx = PEND_IDLE;
				if (is_hex(b)) begin
					if (reserved) begin
						slot[0] = CH_PCT;
						slot[1] = fd_q;
						slot[2] = b;
						cnt = 3'd3;
					end else if (!control) begin
						slot[0] = code;
						cnt = 3'd1;
					end
				end else begin
					slot[0] = CH_PCT;
					slot[1] = fd_q;
					cnt = 3'd2;
					idle = 1'b1;
				end
			end
			default: idle = 1'b1;
		endcase

		// The byte that broke an escape is handled as if nothing were pending.
		if (idle) begin
			pend_nx = PEND_IDLE;
			if (b == CH_PCT) begin
				pend_nx = PEND_PCT;
			end else begin
				slot[cnt[1:0]] = (cfg.plus_to_space && b == CH_PLUS) ? CH_SPACE : b;
				cnt = cnt + 3'd1;
			end
		end

		// End of string: flush a pending escape raw.
		if (word_s1.in_last) begin
			if (pend_nx == PEND_PCT) begin
				slot[cnt[1:0]] = CH_PCT;
				cnt = cnt + 3'd1;
			end else if (pend_nx == PEND_DIGIT) begin
				slot[cnt[1:0]] = CH_PCT;
				cnt = cnt + 3'd1;
				slot[cnt[1:0]] = fd_nx;
				cnt = cnt + 3'd1;
			end
			pend_nx = PEND_IDLE;
			if (cnt == 3'd0) begin
				has = 1'b0;
				cnt = 3'd1;
			end
		end
	end

	assign grp.bytes    = slot;
	assign grp.count    = cnt[1:0];
	assign grp.has_byte = has;
	assign grp.last     = word_s1.in_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= PEND_IDLE;
			fd_q   <= '0;
		end else if (step) begin
			pend_q <= pend_nx;
			fd_q   <= fd_nx;
		end
	end

	a_pend_legal: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("escape state holds an unused code");

endmodule

FILE: sv/pdec_emit.sv
// ----------------------------------------------------------------------------
// pdec_emit: result group register and serializer
// Holds the group of result words for one raw word and hands them out one
// word per handshake. A new group may load as the final word leaves.
// ----------------------------------------------------------------------------
module pdec_emit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pdec_pkg::grp_t       grp,
	input  logic                 load,
	output logic                 free,
	output logic                 dec_valid,
	input  logic                 dec_stall,
	output pdec_pkg::dec_word_t  dec_word
);
	import pdec_pkg::*;

	grp_t       grp_q;
	logic       full_q;
	logic [1:0] idx_q;
	logic       take;
	logic       final_word;

	assign take       = full_q && !dec_stall;
	assign final_word = (idx_q == grp_q.count - 2'd1);
	assign free       = !full_q || (take && final_word);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			idx_q  <= '0;
		end else if (free) begin
			full_q <= load && (grp.count != 2'd0);
			idx_q  <= '0;
		end else if (take) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			grp_q <= grp;
		end
	end

	assign dec_valid         = full_q;
	assign dec_word.out_byte = grp_q.bytes[idx_q];
	assign dec_word.has_byte = grp_q.has_byte;
	assign dec_word.out_last = grp_q.last && final_word;

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |-> grp_q.count != 2'd0)
		else $error("held group has no words");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |-> idx_q < grp_q.count)
		else $error("word index runs past the group");

	a_group_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !final_word) |=> full_q && idx_q == $past(idx_q) + 2'd1)
		else $error("group lost before its final word left");

endmodule

FILE: sv/percent_decoder_stream_core.sv
// ----------------------------------------------------------------------------
// percent_decoder_stream_core: streaming URL percent-escape decoder
// Raw words enter through an input register; a single pass of decode logic
// turns each into zero to three result words, held in a group register that
// drains one word per cycle while dec_stall is low. A raw word giving one
// result or none lets the block sustain one raw word per cycle while
// dec_stall is low; one giving two or three results holds the group register
// until they have all left, and the next raw word stalls while it drains.
// The user must write configuration only while idle; the block does not
// enforce it.
// ----------------------------------------------------------------------------
module percent_decoder_stream_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pdec_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pdec_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              raw_valid,
	output logic                              raw_stall,
	input  pdec_pkg::raw_word_t               raw_word,
	output logic                              dec_valid,
	input  logic                              dec_stall,
	output pdec_pkg::dec_word_t               dec_word
);
	import pdec_pkg::*;

	cfg_t      cfg;
	raw_word_t word_s1;
	logic      valid_s1;
	grp_t      grp;
	logic      free;
	logic      step;
	logic      accept;

	assign step      = valid_s1 && free;
	assign raw_stall = valid_s1 && !free;
	assign accept    = raw_valid && !raw_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= raw_word;
		end
	end

	pdec_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pdec_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.word_s1 (word_s1),
		.step    (step),
		.grp     (grp)
	);

	pdec_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.grp       (grp),
		.load      (step),
		.free      (free),
		.dec_valid (dec_valid),
		.dec_stall (dec_stall),
		.dec_word  (dec_word)
	);

endmodule
